/* rtl/core/wrr_pkg.sv */
// Package for the weighted round-robin selector: transfer types, commands, states.
// No dependencies.
`timescale 1ns / 1ps
package wrr_pkg;
  // table size and weight width are tied to the transfer field widths below
  localparam int TABLE_ENTRIES = 16;
  localparam int WEIGHT_BITS   = 16;

  typedef enum logic [2:0] {
    CMD_WRITE   = 3'd0,
    CMD_REBUILD = 3'd1,
    CMD_SELECT  = 3'd2,
    CMD_READ    = 3'd3,
    CMD_RELEASE = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_PICKED = 2'd1,
    ST_NONE   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RB_LOAD,
    S_RB_MOD,
    S_SEL_STEP,
    S_SEL_EVAL,
    S_OUT
  } state_e;

  localparam logic [7:0] ADDR_ACTIVE = 8'd0;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  entry_index;
    logic [15:0] new_server_id;
    logic [15:0] new_weight;
    logic        new_down;
    logic [7:0]  new_prefetch;
    logic        new_has_errors;
    logic        new_err_high;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  picked_index;
    logic [15:0] picked_server_id;
    logic [15:0] used_count;
    logic [15:0] refused_count;
    logic [15:0] open_conns;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic busy;
  } mod_ctrl_t;
endpackage

/* rtl/core/wrr_mod_unit.sv */
// Shared restoring remainder unit: one quotient bit per cycle.
// Depends on wrr_pkg.
`timescale 1ns / 1ps
module wrr_mod_unit #(
  parameter int W = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [W-1:0]      a_i,
  input  logic [W-1:0]      b_i,
  output wrr_pkg::mod_ctrl_t ctrl_o,
  output logic [W-1:0]      rem_o
);
  import wrr_pkg::*;
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] rem_q, rem_d, dvd_q, dvd_d, b_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [W:0] trial;

  always_comb begin
    rem_d = rem_q; dvd_d = dvd_q; cnt_d = cnt_q; busy_d = busy_q;
    trial = {rem_q, dvd_q[W-1]} - {1'b0, b_q};
    if (start_i) begin
      rem_d = '0; dvd_d = a_i; cnt_d = CW'(W); busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) rem_d = trial[W-1:0];
      else rem_d = {rem_q[W-2:0], dvd_q[W-1]};
      dvd_d = {dvd_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; dvd_q <= dvd_d;
    if (start_i) b_q <= b_i;
  end

  assign rem_o = rem_q;
  assign ctrl_o = '{start: start_i, busy: busy_q};
endmodule

/* rtl/core/weighted_round_robin_selector_core.sv */
// Top level of the weighted round-robin selector core.
// Depends on wrr_pkg and wrr_mod_unit.
`timescale 1ns / 1ps
// Usage:
//  - Input channel (in_valid_i/in_stall_o/in_data_i) carries one command per
//    transfer: write, rebuild, select, read or release of a 16-entry table.
//  - Output channel (out_valid_o/out_stall_i/out_data_o) returns exactly one
//    result per command, held in an output register until taken.
//  - APB port writes active_entries (address 0); pready is tied high.
//  - One command at a time: in_stall_o is high from acceptance until the
//    result has been transferred out.
//  - From acceptance to out_valid_o: write/read/release go straight to
//    the output state. Select runs round-robin steps (step then evaluate),
//    up to active_entries+1 steps, then the output state; a reload with
//    zero max weight ends in the step state. A position left beyond the
//    active count by a config change is first reduced by subtracting the
//    count. Rebuild visits each entry in turn and runs each Euclid
//    remainder step through the shared bit-serial remainder unit.
//  - The next command is taken the cycle after the result transfer.
//  - Reset clears the overload marks, counters, position, gcd and max
//    weight, totals; table payload is undefined until written. No clearing pass.
//  - A stalled receiver holds the result; nothing else is lost.
module weighted_round_robin_selector_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  wrr_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wrr_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import wrr_pkg::*;
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = WEIGHT_BITS + 2;
  localparam int NW = $clog2(TABLE_ENTRIES + 2);

  // table storage
  logic [15:0]            id_q  [TABLE_ENTRIES];
  logic [WEIGHT_BITS-1:0] wt_q  [TABLE_ENTRIES];
  logic                   dn_q  [TABLE_ENTRIES];
  logic [7:0]             cr_q  [TABLE_ENTRIES];
  logic                   er_q  [TABLE_ENTRIES];
  logic                   eh_q  [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] ov_q;
  logic [15:0]            used_q [TABLE_ENTRIES];
  logic [15:0]            ref_q  [TABLE_ENTRIES];

  logic [IW-1:0] pos_q;
  logic [CW-1:0] cur_q;
  logic [WEIGHT_BITS-1:0] gcd_q, max_q;
  logic [15:0] conn_q;
  logic [4:0] active_q;

  state_e state_q, state_d;
  in_item_t req_q;
  out_item_t res_q;
  logic out_v_q;
  logic [NW-1:0] step_q;
  logic [IW-1:0] ri_q;
  logic [WEIGHT_BITS-1:0] ga_q, gb_q, gm_q;

  // config: word decode on paddr[2]
  logic cfg_sel;
  logic cfg_wr;
  assign cfg_sel = (paddr[2] == ADDR_ACTIVE[2]);
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = cfg_sel ? {27'd0, active_q} : 32'd0;

  logic [NW-1:0] live;
  always_comb begin
    if (active_q == 5'd0) live = NW'(1);
    else if (32'(active_q) > TABLE_ENTRIES) live = NW'(TABLE_ENTRIES);
    else live = NW'(active_q);
  end

  assign in_stall_o = (state_q != S_IDLE) || out_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o = res_q;
  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // shared remainder unit
  mod_ctrl_t mc;
  logic mod_start;
  logic [WEIGHT_BITS-1:0] mod_rem;
  wrr_mod_unit #(.W(WEIGHT_BITS)) u_mod (
    .clk_i, .rst_ni, .start_i(mod_start), .a_i(ga_q), .b_i(gb_q),
    .ctrl_o(mc), .rem_o(mod_rem)
  );

  // position beyond the active count: reduce it first, one subtraction a cycle
  logic pos_hi;
  assign pos_hi = (NW'(pos_q) >= live);

  // next position in the ring
  logic [IW-1:0] npos;
  logic wrap;
  always_comb begin
    logic [NW-1:0] p1;
    p1 = NW'(pos_q) + NW'(1);
    if (p1 >= live) p1 = p1 - live;
    if (p1 >= live) p1 = '0;
    npos = p1[IW-1:0];
    wrap = (p1 == '0);
  end

  logic [IW-1:0] ix;
  assign ix = pos_q;
  logic over_eval;
  assign over_eval = (er_q[ix] && cr_q[ix] == 8'd0) || eh_q[ix];
  logic over;
  assign over = ov_q[ix] || over_eval;
  // entry under evaluation is live, up, heavy enough and not blocked by overload
  logic sel_hit;
  assign sel_hit = (wt_q[ix] != '0) && !dn_q[ix] && (CW'(wt_q[ix]) >= cur_q);
  logic pick;
  assign pick = sel_hit && !(cr_q[ix] == 8'd0 && over);

  always_comb begin
    state_d = state_q;
    mod_start = 1'b0;
    case (state_q)
      S_IDLE: if (in_acc) begin
        case (in_data_i.cmd)
          CMD_REBUILD: state_d = S_RB_LOAD;
          CMD_SELECT:  state_d = S_SEL_STEP;
          default:     state_d = S_OUT;
        endcase
      end
      S_RB_LOAD: if (gb_q != '0) begin
        mod_start = 1'b1; state_d = S_RB_MOD;
      end else if (NW'(ri_q) + NW'(1) >= live) state_d = S_OUT;
      S_RB_MOD: if (!mc.start && !mc.busy) state_d = S_RB_LOAD;
      S_SEL_STEP: begin
        if (pos_hi) state_d = S_SEL_STEP;
        else if (wrap && cur_q <= CW'(gcd_q) && max_q == '0) state_d = S_OUT;
        else state_d = S_SEL_EVAL;
      end
      S_SEL_EVAL: state_d = (pick || step_q >= live) ? S_OUT : S_SEL_STEP;
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; out_v_q <= 1'b0; ov_q <= '0;
      pos_q <= '0; cur_q <= '0; gcd_q <= '0; max_q <= '0; conn_q <= '0;
      active_q <= 5'd1; step_q <= '0; ri_q <= '0;
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        used_q[k] <= '0; ref_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_wr && cfg_sel) active_q <= pwdata[4:0];
      if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_acc) begin
          req_q <= in_data_i;
          res_q <= '0;
          step_q <= '0;
          ri_q <= '0;
          ga_q <= wt_q[0]; gb_q <= '0; gm_q <= '0;
          if (in_data_i.cmd == CMD_WRITE && 32'(in_data_i.entry_index) < TABLE_ENTRIES)
          begin
            id_q[in_data_i.entry_index[IW-1:0]] <= in_data_i.new_server_id;
            wt_q[in_data_i.entry_index[IW-1:0]] <= in_data_i.new_weight[WEIGHT_BITS-1:0];
            dn_q[in_data_i.entry_index[IW-1:0]] <= in_data_i.new_down;
            cr_q[in_data_i.entry_index[IW-1:0]] <= in_data_i.new_prefetch;
            er_q[in_data_i.entry_index[IW-1:0]] <= in_data_i.new_has_errors;
            eh_q[in_data_i.entry_index[IW-1:0]] <= in_data_i.new_err_high;
            ov_q[in_data_i.entry_index[IW-1:0]] <= 1'b0;
            used_q[in_data_i.entry_index[IW-1:0]] <= '0;
            ref_q[in_data_i.entry_index[IW-1:0]] <= '0;
          end
          if (in_data_i.cmd == CMD_RELEASE && conn_q != 16'd0) conn_q <= conn_q - 1'b1;
        end
        // g = euclid(w, g): a=w, b=g; iterate (a,b)=(b,a%b)
        S_RB_LOAD: begin
          if (ga_q > gm_q) gm_q <= ga_q;
          if (gb_q == '0) begin
            if (NW'(ri_q) + NW'(1) >= live) begin
              gcd_q <= ga_q;
              max_q <= (ga_q > gm_q) ? ga_q : gm_q;
            end else begin
              ri_q <= ri_q + 1'b1;
              gb_q <= ga_q;
              ga_q <= wt_q[ri_q + 1'b1];
            end
          end
        end
        S_RB_MOD: if (!mc.start && !mc.busy) begin
          ga_q <= gb_q; gb_q <= mod_rem;
        end
        S_SEL_STEP: begin
          if (pos_hi) begin
            pos_q <= IW'(NW'(pos_q) - live);
          end else begin
            pos_q <= npos;
            if (wrap) begin
              if (cur_q <= CW'(gcd_q)) begin
                cur_q <= CW'(max_q);
                if (max_q == '0) res_q.status <= ST_NONE;
              end else cur_q <= cur_q - CW'(gcd_q);
            end
          end
        end
        S_SEL_EVAL: begin
          step_q <= step_q + 1'b1;
          res_q.status <= pick ? ST_PICKED : ST_NONE;
          if (wt_q[ix] != '0) begin
            if (dn_q[ix]) begin
              if (ref_q[ix] != 16'hFFFF) ref_q[ix] <= ref_q[ix] + 1'b1;
            end else if (CW'(wt_q[ix]) >= cur_q) begin
              if (!ov_q[ix]) ov_q[ix] <= over_eval;
              if (!pick) begin
                if (ref_q[ix] != 16'hFFFF) ref_q[ix] <= ref_q[ix] + 1'b1;
              end else begin
                if (over) cr_q[ix] <= cr_q[ix] - 1'b1;
                if (conn_q != 16'hFFFF) conn_q <= conn_q + 1'b1;
                if (used_q[ix] != 16'hFFFF) used_q[ix] <= used_q[ix] + 1'b1;
                res_q.picked_index <= 4'(ix);
              end
            end
          end
        end
        S_OUT: begin
          out_v_q <= 1'b1;
          res_q.open_conns <= conn_q;
          if (req_q.cmd == CMD_READ && 32'(req_q.entry_index) < TABLE_ENTRIES) begin
            res_q.picked_index <= req_q.entry_index;
            res_q.picked_server_id <= id_q[req_q.entry_index[IW-1:0]];
            res_q.used_count <= used_q[req_q.entry_index[IW-1:0]];
            res_q.refused_count <= ref_q[req_q.entry_index[IW-1:0]];
          end else if (res_q.status == ST_PICKED) begin
            res_q.picked_server_id <= id_q[res_q.picked_index[IW-1:0]];
            res_q.used_count <= used_q[res_q.picked_index[IW-1:0]];
            res_q.refused_count <= ref_q[res_q.picked_index[IW-1:0]];
          end
        end
        default: ;
      endcase
    end
  end
endmodule

/* rtl/core/wrr_checker.sv */
// Port-level checker for the selector core, bound to the top level.
// Depends on wrr_pkg.
`timescale 1ns / 1ps
module wrr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input wrr_pkg::out_item_t out_data_o
);
  import wrr_pkg::*;
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted a second command while busy");
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status != 2'd3)
    else $error("bad status");
  a_nopick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_NONE |-> out_data_o.picked_index == 4'd0)
    else $error("index on empty select");
endmodule

bind weighted_round_robin_selector_core wrr_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);
